// ===== design/pdc_pkg.sv =====
// shared types and constants of the pll divider setting calculator
package pdc_pkg;

   localparam int DIV_W   = 32;
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int F_W     = 20;
   localparam int REF_W   = 17;
   localparam int Q0_W    = 10;
   localparam int Q_W     = 8;
   localparam int P_W     = 12;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   // register indexes on the csr port
   localparam logic [1:0] REG_REFERENCE = 2'd0;
   localparam logic [1:0] REG_MIN_TGT   = 2'd1;
   localparam logic [1:0] REG_MAX_TGT   = 2'd2;

   localparam logic [REF_W-1:0] RESET_REFERENCE = 17'd33000;
   localparam logic [F_W-1:0]   RESET_MIN_TGT   = 20'd25000;
   localparam logic [F_W-1:0]   RESET_MAX_TGT   = 20'd133000;

   localparam logic [MUL_B_W-1:0] SCALE_K   = 24'd2000;
   localparam logic [DIV_W-1:0]   AQ_LIMIT  = 32'd2055000;
   localparam logic [DIV_W-1:0]   Q_DIVISOR = 32'd250;
   localparam logic [DIV_W-1:0]   KHZ_DIV   = 32'd1000;
   localparam logic [PROD_W-1:0]  PLL_MIN   = 56'd100000;
   localparam logic [PROD_W-1:0]  PLL_MAX   = 56'd400000;
   localparam logic [DIV_W-1:0]   Q_MIN     = 32'd2;
   localparam logic [DIV_W-1:0]   Q_MAX     = 32'd129;
   localparam logic [DIV_W-1:0]   P_MIN     = 32'd8;
   localparam logic [DIV_W-1:0]   P_MAX     = 32'd2055;
   localparam logic [F_W-1:0]     BAND_HI   = 20'd77000;
   localparam logic [F_W-1:0]     BAND_LO   = 20'd51000;

   localparam logic [7:0] CP_BASE   = 8'hC0;
   localparam logic [7:0] CP_RANGE1 = 8'h04;
   localparam logic [7:0] CP_RANGE2 = 8'h08;
   localparam logic [7:0] CP_RANGE3 = 8'h0C;
   localparam logic [7:0] CP_RANGE4 = 8'h10;
   localparam logic [7:0] MTX_DF    = 8'hDF;
   localparam logic [7:0] MTX_B7    = 8'hB7;
   localparam logic [7:0] MTX_DE    = 8'hDE;
   localparam logic [7:0] MTX_6F    = 8'h6F;

   typedef struct packed {
      logic [REF_W-1:0] reference_khz;
      logic [F_W-1:0]   min_target_khz;
      logic [F_W-1:0]   max_target_khz;
   } cfg_type;

   typedef struct packed {
      logic             go;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               go;
      logic [MUL_A_W-1:0] mcand;
      logic [MUL_B_W-1:0] mplier;
   } mul_req_type;

endpackage

// ===== design/pll_divider_setting_calc.sv =====
// top level: pll divider setting calculator with sequencer and result register
//
// A target frequency in kHz arrives on the req_ channel (req_valid/req_stall)
// and one result beat leaves on the rsp_ channel (rsp_valid/rsp_stall): the
// error flag plus the pb, q, charge-pump and two output-matrix bytes.
// The csr_ port holds the reference frequency and the accepted target range;
// write it only while no beat is in flight.
// One item is worked on at a time. The arithmetic runs on one bit-serial
// divider and one bit-serial multiplier, used in turn by the sequencer:
// three products and five divisions for a valid target; a target outside
// the range is rejected without any arithmetic, and other rejects end early.
// req_stall is high from the accept until the result is loaded into the
// output register. A finished result waits in the output register while
// rsp_stall is high; the next item may be accepted meanwhile, but its own
// result is held back until the earlier beat has gone.
// Reset is synchronous; it returns the registers to 33000/25000/133000 kHz,
// drops rsp_valid and puts the sequencer back to idle.
module pll_divider_setting_calc (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [19:0]                 req_target_khz,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_error_code,
   output logic [7:0]                  rsp_pb_counter,
   output logic [7:0]                  rsp_q_counter,
   output logic [7:0]                  rsp_charge_pump,
   output logic [7:0]                  rsp_matrix_two,
   output logic [7:0]                  rsp_matrix_three,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pdc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [pdc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [pdc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import pdc_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL_A = 4'd1;
   localparam logic [3:0] S_DIV_A = 4'd2;
   localparam logic [3:0] S_DIV_Q = 4'd3;
   localparam logic [3:0] S_DIV_D = 4'd4;
   localparam logic [3:0] S_DIV_K = 4'd5;
   localparam logic [3:0] S_MUL_P = 4'd6;
   localparam logic [3:0] S_MUL_S = 4'd7;
   localparam logic [3:0] S_DIV_P = 4'd8;
   localparam logic [3:0] S_WAIT  = 4'd9;

   cfg_type              cfg;
   div_req_type          div_req_ff, div_req_in;
   mul_req_type          mul_req_ff, mul_req_in;
   logic                 div_done;
   logic [DIV_W-1:0]     quo;
   logic                 mul_done;
   logic [PROD_W-1:0]    prod;

   logic [3:0]           state_ff, state_in;
   logic [F_W-1:0]       f_ff, f_in;
   logic [DIV_W-1:0]     a_ff, a_in;
   logic [Q0_W-1:0]      q0_ff, q0_in;
   logic [Q_W-1:0]       q_ff, q_in;
   logic [P_W-1:0]       p_ff, p_in;
   logic                 err_ff, err_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 err_out_ff;
   logic [7:0]           pb_out_ff, qc_out_ff, cp_out_ff, m2_out_ff, m3_out_ff;

   logic                 req_take;
   logic                 load_out;
   logic [DIV_W-1:0]     q0_ext;
   logic [DIV_W-1:0]     q_sel;
   logic [P_W-2:0]       pb_full;
   logic [Q_W-1:0]       q_m2;
   logic [7:0]           cp_code;
   logic [7:0]           pb_byte, qc_byte, cp_byte, m2_byte, m3_byte;

   pdc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req_ff),
      .done     (div_done),
      .quotient (quo)
   );

   pdc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req_ff),
      .done    (mul_done),
      .product (prod)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign load_out  = (state_ff == S_WAIT) & (~rsp_valid_ff | ~rsp_stall);

   // largest q not above the start value with a*q inside the limit
   assign q0_ext = {{(DIV_W-Q0_W){1'b0}}, q0_ff};
   assign q_sel  = (quo < q0_ext) ? quo : q0_ext;

   always_comb begin
      state_in   = state_ff;
      f_in       = f_ff;
      a_in       = a_ff;
      q0_in      = q0_ff;
      q_in       = q_ff;
      p_in       = p_ff;
      err_in     = err_ff;
      div_req_in = '{go: 1'b0, dividend: div_req_ff.dividend,
                     divisor: div_req_ff.divisor};
      mul_req_in = '{go: 1'b0, mcand: mul_req_ff.mcand, mplier: mul_req_ff.mplier};
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               f_in = req_target_khz;
               if (req_target_khz < cfg.min_target_khz ||
                   req_target_khz > cfg.max_target_khz ||
                   cfg.reference_khz == '0) begin
                  err_in   = 1'b1;
                  state_in = S_WAIT;
               end else begin
                  err_in     = 1'b0;
                  mul_req_in = '{go: 1'b1,
                                 mcand: {{(MUL_A_W-F_W){1'b0}}, req_target_khz},
                                 mplier: SCALE_K};
                  state_in   = S_MUL_A;
               end
            end
         end
         S_MUL_A: begin
            if (mul_done) begin
               div_req_in = '{go: 1'b1, dividend: prod[DIV_W-1:0],
                              divisor: {{(DIV_W-REF_W){1'b0}}, cfg.reference_khz}};
               state_in   = S_DIV_A;
            end
         end
         S_DIV_A: begin
            if (div_done) begin
               a_in       = quo;
               div_req_in = '{go: 1'b1,
                              dividend: {{(DIV_W-REF_W){1'b0}}, cfg.reference_khz},
                              divisor: Q_DIVISOR};
               state_in   = S_DIV_Q;
            end
         end
         S_DIV_Q: begin
            if (div_done) begin
               q0_in = quo[Q0_W-1:0];
               if (quo < Q_MIN) begin
                  err_in   = 1'b1;
                  state_in = S_WAIT;
               end else begin
                  div_req_in = '{go: 1'b1, dividend: AQ_LIMIT, divisor: a_ff};
                  state_in   = S_DIV_D;
               end
            end
         end
         S_DIV_D: begin
            if (div_done) begin
               if (q_sel < Q_MIN || q_sel > Q_MAX) begin
                  err_in   = 1'b1;
                  state_in = S_WAIT;
               end else begin
                  q_in       = q_sel[Q_W-1:0];
                  div_req_in = '{go: 1'b1, dividend: a_ff, divisor: KHZ_DIV};
                  state_in   = S_DIV_K;
               end
            end
         end
         S_DIV_K: begin
            if (div_done) begin
               mul_req_in = '{go: 1'b1,
                              mcand: {{(MUL_A_W-REF_W){1'b0}}, cfg.reference_khz},
                              mplier: quo[MUL_B_W-1:0]};
               state_in   = S_MUL_P;
            end
         end
         S_MUL_P: begin
            if (mul_done) begin
               if (prod < PLL_MIN || prod > PLL_MAX) begin
                  err_in   = 1'b1;
                  state_in = S_WAIT;
               end else begin
                  mul_req_in = '{go: 1'b1, mcand: a_ff,
                                 mplier: {{(MUL_B_W-Q_W){1'b0}}, q_ff}};
                  state_in   = S_MUL_S;
               end
            end
         end
         S_MUL_S: begin
            // a*q stays within the limit here, so the low word is the whole product
            if (mul_done) begin
               div_req_in = '{go: 1'b1, dividend: prod[DIV_W-1:0], divisor: KHZ_DIV};
               state_in   = S_DIV_P;
            end
         end
         S_DIV_P: begin
            if (div_done) begin
               p_in = quo[P_W-1:0];
               if (quo < P_MIN || quo > P_MAX) begin
                  err_in = 1'b1;
               end
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result bytes from the settled p, q and target
   assign pb_full = p_ff[P_W-1:1] - 11'd4;
   assign q_m2    = q_ff - 8'd2;

   always_comb begin
      if (p_ff >= 12'd45 && p_ff <= 12'd479) begin
         cp_code = CP_RANGE1;
      end else if (p_ff >= 12'd480 && p_ff <= 12'd639) begin
         cp_code = CP_RANGE2;
      end else if (p_ff >= 12'd640 && p_ff <= 12'd799) begin
         cp_code = CP_RANGE3;
      end else if (p_ff >= 12'd800) begin
         cp_code = CP_RANGE4;
      end else begin
         cp_code = 8'h00;
      end
   end

   always_comb begin
      pb_byte = pb_full[7:0];
      qc_byte = {p_ff[0], q_m2[6:0]};
      cp_byte = CP_BASE | {6'b0, pb_full[9:8]} | cp_code;
      if (f_ff > BAND_HI) begin
         m2_byte = MTX_DF;
         m3_byte = MTX_B7;
      end else if (f_ff > BAND_LO) begin
         m2_byte = MTX_DE;
         m3_byte = MTX_DF;
      end else begin
         m2_byte = MTX_DF;
         m3_byte = MTX_6F;
      end
   end

   assign rsp_valid_in = load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         div_req_ff.go <= 1'b0;
         mul_req_ff.go <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         div_req_ff.go <= div_req_in.go;
         mul_req_ff.go <= mul_req_in.go;
      end
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
      mul_req_ff.mcand    <= mul_req_in.mcand;
      mul_req_ff.mplier   <= mul_req_in.mplier;
      f_ff   <= f_in;
      a_ff   <= a_in;
      q0_ff  <= q0_in;
      q_ff   <= q_in;
      p_ff   <= p_in;
      err_ff <= err_in;
      if (load_out) begin
         err_out_ff <= err_ff;
         pb_out_ff  <= err_ff ? 8'h00 : pb_byte;
         qc_out_ff  <= err_ff ? 8'h00 : qc_byte;
         cp_out_ff  <= err_ff ? 8'h00 : cp_byte;
         m2_out_ff  <= err_ff ? 8'h00 : m2_byte;
         m3_out_ff  <= err_ff ? 8'h00 : m3_byte;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_error_code   = err_out_ff;
   assign rsp_pb_counter   = pb_out_ff;
   assign rsp_q_counter    = qc_out_ff;
   assign rsp_charge_pump  = cp_out_ff;
   assign rsp_matrix_two   = m2_out_ff;
   assign rsp_matrix_three = m3_out_ff;

endmodule

// ===== design/pdc_csr.sv =====
// configuration registers behind the apb-style csr port
module pdc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pdc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [pdc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [pdc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output pdc_pkg::cfg_type            cfg
);
   import pdc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_REFERENCE: cfg_in.reference_khz  = csr_pwdata[REF_W-1:0];
            REG_MIN_TGT:   cfg_in.min_target_khz = csr_pwdata[F_W-1:0];
            REG_MAX_TGT:   cfg_in.max_target_khz = csr_pwdata[F_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_REFERENCE: csr_prdata = {{(DATA_W-REF_W){1'b0}}, cfg_ff.reference_khz};
         REG_MIN_TGT:   csr_prdata = {{(DATA_W-F_W){1'b0}}, cfg_ff.min_target_khz};
         REG_MAX_TGT:   csr_prdata = {{(DATA_W-F_W){1'b0}}, cfg_ff.max_target_khz};
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reference_khz  <= RESET_REFERENCE;
         cfg_ff.min_target_khz <= RESET_MIN_TGT;
         cfg_ff.max_target_khz <= RESET_MAX_TGT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/pdc_div.sv =====
// restoring divider, one quotient bit per cycle
module pdc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  pdc_pkg::div_req_type       req,
   output logic                       done,
   output logic [pdc_pkg::DIV_W-1:0]  quotient
);
   import pdc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.go) begin
         rem_in = '0;
         quo_in = req.dividend;
         dvs_in = req.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/pdc_mul.sv =====
// shift-and-add multiplier, one multiplier bit per cycle
module pdc_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  pdc_pkg::mul_req_type        req,
   output logic                        done,
   output logic [pdc_pkg::PROD_W-1:0]  product
);
   import pdc_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_B_W - 1);

   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0]  mcd_ff, mcd_in;
   logic [MUL_B_W-1:0] mpl_ff, mpl_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      mcd_in  = mcd_ff;
      mpl_in  = mpl_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.go) begin
         acc_in = '0;
         mcd_in = {{MUL_B_W{1'b0}}, req.mcand};
         mpl_in = req.mplier;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (mpl_ff[0]) begin
            acc_in = acc_ff + mcd_ff;
         end
         mcd_in = {mcd_ff[PROD_W-2:0], 1'b0};
         mpl_in = {1'b0, mpl_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mcd_ff <= mcd_in;
      mpl_ff <= mpl_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== bench/pll_divider_setting_calc_tb.sv =====
// testbench of the pll divider setting calculator: random targets, csr phases, scoreboard
module pll_divider_setting_calc_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pdc_pkg::*;

   localparam int          CYCLE_LIMIT = 1_500_000;
   localparam int          DRAIN_WAIT  = 300;
   localparam logic        ERR_NONE    = 1'b0;
   localparam logic        ERR_REJECT  = 1'b1;
   // index beyond the register file, writes to it must be dropped
   localparam logic [1:0]  REG_SPARE   = 2'd3;

   typedef struct packed {
      logic       error_code;
      logic [7:0] pb_counter;
      logic [7:0] q_counter;
      logic [7:0] charge_pump;
      logic [7:0] matrix_two;
      logic [7:0] matrix_three;
   } pll_setting_type;

   class pll_setting_board;
      logic [REF_W-1:0] reference_khz;
      logic [F_W-1:0]   min_target_khz;
      logic [F_W-1:0]   max_target_khz;
      pll_setting_type  expected_settings[$];
      int               mismatches;

      function new();
         reference_khz  = RESET_REFERENCE;
         min_target_khz = RESET_MIN_TGT;
         max_target_khz = RESET_MAX_TGT;
         mismatches     = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_REFERENCE: reference_khz  = value[REF_W-1:0];
            REG_MIN_TGT:   min_target_khz = value[F_W-1:0];
            REG_MAX_TGT:   max_target_khz = value[F_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [DATA_W-1:0] reg_value(logic [1:0] idx);
         case (idx)
            REG_REFERENCE: reg_value = DATA_W'(reference_khz);
            REG_MIN_TGT:   reg_value = DATA_W'(min_target_khz);
            REG_MAX_TGT:   reg_value = DATA_W'(max_target_khz);
            default:       reg_value = '0;
         endcase
      endfunction

      function pll_setting_type calc_settings(logic [F_W-1:0] target);
         pll_setting_type s;
         logic [63:0]     ratio, q, pll, p, pb, qbyte;
         s = '0;
         s.error_code = ERR_REJECT;
         if (target < min_target_khz || target > max_target_khz || reference_khz == 0)
            return s;
         ratio = (64'(target) * 64'(SCALE_K)) / 64'(reference_khz);
         q = 64'(reference_khz) / 64'(Q_DIVISOR);
         while (ratio * q > 64'(AQ_LIMIT) && q >= 64'(Q_MIN))
            q = q - 1;
         if (q < 64'(Q_MIN) || q > 64'(Q_MAX))
            return s;
         pll = (ratio / 64'(KHZ_DIV)) * 64'(reference_khz);
         if (pll < 64'(PLL_MIN) || pll > 64'(PLL_MAX))
            return s;
         p = (ratio * q) / 64'(KHZ_DIV);
         if (p < 64'(P_MIN) || p > 64'(P_MAX))
            return s;
         pb = (p >> 1) - 4;
         s.charge_pump = CP_BASE | pb[15:8];
         if (p >= 45 && p <= 479)
            s.charge_pump = s.charge_pump | CP_RANGE1;
         else if (p >= 480 && p <= 639)
            s.charge_pump = s.charge_pump | CP_RANGE2;
         else if (p >= 640 && p <= 799)
            s.charge_pump = s.charge_pump | CP_RANGE3;
         else if (p >= 800)
            s.charge_pump = s.charge_pump | CP_RANGE4;
         if (target > BAND_HI) begin
            s.matrix_two   = MTX_DF;
            s.matrix_three = MTX_B7;
         end else if (target > BAND_LO) begin
            s.matrix_two   = MTX_DE;
            s.matrix_three = MTX_DF;
         end else begin
            s.matrix_two   = MTX_DF;
            s.matrix_three = MTX_6F;
         end
         qbyte = ((p & 64'd1) << 7) + q - 2;
         s.error_code = ERR_NONE;
         s.pb_counter = pb[7:0];
         s.q_counter  = qbyte[7:0];
         return s;
      endfunction

      function void note_target(logic [F_W-1:0] target);
         expected_settings.push_back(calc_settings(target));
      endfunction

      function int pending();
         return expected_settings.size();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task check_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("%s got %02h want %02h", name, got, want));
      endtask

      task check_result(pll_setting_type got);
         pll_setting_type want;
         if (expected_settings.size() == 0) begin
            report("result beat with nothing outstanding");
            return;
         end
         want = expected_settings.pop_front();
         check_field("error_code", 8'(got.error_code), 8'(want.error_code));
         check_field("pb_counter", got.pb_counter, want.pb_counter);
         check_field("q_counter", got.q_counter, want.q_counter);
         check_field("charge_pump", got.charge_pump, want.charge_pump);
         check_field("matrix_two", got.matrix_two, want.matrix_two);
         check_field("matrix_three", got.matrix_three, want.matrix_three);
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [F_W-1:0]     req_target_khz;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_error_code;
   logic [7:0]         rsp_pb_counter;
   logic [7:0]         rsp_q_counter;
   logic [7:0]         rsp_charge_pump;
   logic [7:0]         rsp_matrix_two;
   logic [7:0]         rsp_matrix_three;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [ADDR_W-1:0]  csr_paddr;
   logic [DATA_W-1:0]  csr_pwdata;
   logic [DATA_W-1:0]  csr_prdata;
   logic               csr_pready;

   pll_setting_board   board;
   int                 cycle_count;
   int                 send_calm;
   int                 recv_calm;

   pll_divider_setting_calc u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_target_khz   (req_target_khz),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_error_code   (rsp_error_code),
      .rsp_pb_counter   (rsp_pb_counter),
      .rsp_q_counter    (rsp_q_counter),
      .rsp_charge_pump  (rsp_charge_pump),
      .rsp_matrix_two   (rsp_matrix_two),
      .rsp_matrix_three (rsp_matrix_three),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // wait length per beat, with occasional runs of back-to-back beats
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         calm = $urandom_range(10, 40);
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [F_W-1:0] pick_target(logic [F_W-1:0] lo, logic [F_W-1:0] hi);
      int sel;
      int val;
      sel = $urandom_range(0, 99);
      if (sel < 65)
         return F_W'($urandom_range(45000, 210000));
      if (sel < 82) begin
         val = (sel[0] ? int'(lo) : int'(hi)) + $urandom_range(0, 4) - 2;
         if (val < 0)
            val = 0;
         if (val > 1048575)
            val = 1048575;
         return F_W'(val);
      end
      return F_W'($urandom);
   endfunction

   // all tasks below start and end at a falling edge
   task drive_target(logic [F_W-1:0] target);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_target_khz <= target;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_target(target);
      @(negedge clock);
   endtask

   task wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task csr_write(logic [1:0] idx, logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task csr_read_check(logic [1:0] idx);
      logic [DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      got = csr_prdata;
      if (got !== board.reg_value(idx))
         board.report($sformatf("register %0d reads %0h want %0h",
                                idx, got, board.reg_value(idx)));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task apply_settings(int ref_khz, int lo_khz, int hi_khz);
      wait_idle();
      csr_write(REG_REFERENCE, DATA_W'(ref_khz));
      csr_write(REG_MIN_TGT, DATA_W'(lo_khz));
      csr_write(REG_MAX_TGT, DATA_W'(hi_khz));
      csr_read_check(REG_REFERENCE);
      csr_read_check(REG_MIN_TGT);
      csr_read_check(REG_MAX_TGT);
   endtask

   // result side: random stall, then take one beat and check it
   initial begin
      int n;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         n = draw_wait(recv_calm);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         board.check_result({rsp_error_code, rsp_pb_counter, rsp_q_counter,
                             rsp_charge_pump, rsp_matrix_two, rsp_matrix_three});
         @(negedge clock);
      end
   end

   initial begin
      int ref_khz;
      int lo_khz;
      int hi_khz;
      board          = new();
      cycle_count    = 0;
      send_calm      = 0;
      recv_calm      = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_target_khz = '0;
      rsp_stall      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: range edges
      drive_target(20'd0);
      drive_target(20'd24999);
      drive_target(20'd25000);
      drive_target(20'd100000);
      drive_target(20'd133000);
      drive_target(20'd133001);

      // open range, band edges and field extremes
      apply_settings(14318, 0, 1048575);
      drive_target(20'd0);
      drive_target(20'd1048575);
      drive_target(20'd45000);
      drive_target(20'd51000);
      drive_target(20'd51001);
      drive_target(20'd77000);
      drive_target(20'd77001);
      drive_target(20'd100000);
      drive_target(20'd150000);
      drive_target(20'd200000);

      // zero reference rejects everything
      apply_settings(0, 0, 1048575);
      drive_target(20'd100000);

      // minimum above maximum
      apply_settings(14318, 200000, 100000);
      drive_target(20'd150000);
      drive_target(20'd50000);

      // single-point range at the top
      apply_settings(131071, 1048575, 1048575);
      drive_target(20'd1048575);
      drive_target(20'd1048574);

      // write past the last register must leave settings alone
      apply_settings(14318, 0, 1048575);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      csr_read_check(REG_REFERENCE);
      drive_target(20'd120000);
      drive_target(20'd66000);

      for (int ph = 0; ph < 8; ph++) begin
         ref_khz = $urandom_range(1000, 40000);
         lo_khz  = $urandom_range(0, 60000);
         hi_khz  = $urandom_range(110000, 1048575);
         if (ph == 3)
            ref_khz = 131071;
         if (ph == 5)
            ref_khz = 1000;
         if (ph == 6) begin
            lo_khz = 0;
            hi_khz = 1048575;
         end
         apply_settings(ref_khz, lo_khz, hi_khz);
         repeat (160)
            drive_target(pick_target(board.min_target_khz, board.max_target_khz));
      end

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
